@@ rtl/bip_pkg.sv @@
// package: token codes, command type and precedence for the infix to postfix unit
package bip_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int MAX_TOKENS  = 255;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = 8;
    localparam int COND_W      = 8;

    // input token kinds
    localparam logic [1:0] MODE_COND = 2'd0;
    localparam logic [1:0] MODE_OPER = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // operator codes on the input side
    localparam logic [2:0] OPC_OR    = 3'd0;
    localparam logic [2:0] OPC_AND   = 3'd1;
    localparam logic [2:0] OPC_NOT   = 3'd2;
    localparam logic [2:0] OPC_OPEN  = 3'd3;
    localparam logic [2:0] OPC_CLOSE = 3'd4;

    // operator codes as stored and emitted
    localparam logic [1:0] SOP_OR   = 2'd0;
    localparam logic [1:0] SOP_AND  = 2'd1;
    localparam logic [1:0] SOP_NOT  = 2'd2;
    localparam logic [1:0] SOP_OPEN = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_COND = 2'd0;
    localparam logic [1:0] KIND_OPER = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_UNMATCH  = 2'd2;

    typedef enum logic [2:0] {
        CMD_COND  = 3'd0,
        CMD_OPER  = 3'd1,
        CMD_OPEN  = 3'd2,
        CMD_CLOSE = 3'd3,
        CMD_END   = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [1:0]         op;
        logic [COND_W-1:0]  cond;
    } cmd_t;

    function automatic logic [1:0] prec_of(input logic [1:0] op);
        logic [1:0] p;
        unique case (op)
            SOP_OR:  p = 2'd1;
            SOP_AND: p = 2'd2;
            SOP_NOT: p = 2'd3;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/bip_if.sv @@
// stream interfaces for tokens in and postfix results out
interface bip_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [2:0] op_code;
    logic [7:0] cond_index;

    modport source (output valid, output mode, output op_code, output cond_index, input ready);
    modport sink   (input valid, input mode, input op_code, input cond_index, output ready);
endinterface

interface bip_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [1:0] out_op;
    logic [7:0] out_cond;
    logic [7:0] out_count;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output out_kind, output out_op, output out_cond,
                    output out_count, output error_code, output last, input ready);
    modport sink   (input valid, input out_kind, input out_op, input out_cond,
                    input out_count, input error_code, input last, output ready);
endinterface

@@ rtl/bip_front.sv @@
// front end: accepts tokens, drops undefined ones and classifies the rest into commands
module bip_front
    import bip_pkg::*;
(
    bip_in_if.sink tokens,
    output logic   cmd_valid,
    output cmd_t   cmd,
    input  logic   cmd_ready
);

    logic legal;

    always_comb
    begin
        legal    = 1'b1;
        cmd.kind = CMD_COND;
        cmd.op   = tokens.op_code[1:0];
        cmd.cond = tokens.cond_index;
        unique case (tokens.mode)
            MODE_COND: cmd.kind = CMD_COND;
            MODE_OPER:
            begin
                unique case (tokens.op_code)
                    OPC_OR, OPC_AND, OPC_NOT: cmd.kind = CMD_OPER;
                    OPC_OPEN:                 cmd.kind = CMD_OPEN;
                    OPC_CLOSE:                cmd.kind = CMD_CLOSE;
                    default:                  legal    = 1'b0;
                endcase
            end
            MODE_END: cmd.kind = CMD_END;
            default:  legal    = 1'b0;
        endcase
    end

    // undefined tokens are still taken, they just never reach the queue
    assign tokens.ready = cmd_ready;
    assign cmd_valid    = tokens.valid && legal;

endmodule

@@ rtl/bip_queue.sv @@
// two-entry command queue between front and back
module bip_queue
    import bip_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    input  cmd_t wr_cmd,
    output logic wr_ready,
    output logic rd_valid,
    output cmd_t rd_cmd,
    input  logic rd_ready
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

@@ rtl/bip_back.sv @@
// back end: operator stack, pop loop and result register
module bip_back
    import bip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_ready,
    bip_out_if.source  results
);

    logic [1:0]        stack_mem [STACK_DEPTH];
    logic [1:0]        top_reg;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        err_reg, err_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [1:0]        hold_op_reg, hold_op_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [1:0]        out_op_reg, out_op_next;
    logic [7:0]        out_cond_reg, out_cond_next;
    logic [7:0]        out_count_reg, out_count_next;
    logic [1:0]        out_err_reg, out_err_next;
    logic              out_last_reg, out_last_next;

    logic [PTR_W-1:0]  ptr_m1;
    logic [PTR_W-1:0]  ptr_m2;
    logic [1:0]        top_op;
    logic [CNT_W-1:0]  cnt_inc;
    logic              can_load;
    logic              load;
    logic              cont;
    logic              push_en;
    logic              pop_en;
    logic [1:0]        push_op;

    assign ptr_m1   = ptr_reg - PTR_W'(1);
    assign ptr_m2   = ptr_reg - PTR_W'(2);
    // top_reg mirrors the entry just below the pointer
    assign top_op   = top_reg;
    assign cnt_inc  = (cnt_reg < CNT_W'(MAX_TOKENS)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign can_load = !out_valid_reg || results.ready;

    always_comb
    begin
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        hold_valid_next = hold_valid_reg;
        hold_op_next    = hold_op_reg;
        cmd_ready       = 1'b0;
        load            = 1'b0;
        push_en         = 1'b0;
        pop_en          = 1'b0;
        push_op         = cmd.op;
        out_kind_next   = KIND_OPER;
        out_op_next     = 2'd0;
        out_cond_next   = 8'd0;
        out_count_next  = 8'd0;
        out_err_next    = err_reg;
        out_last_next   = 1'b0;

        if (cmd.kind == CMD_CLOSE)
            cont = (ptr_reg != '0) && (top_op != SOP_OPEN);
        else
            cont = (ptr_reg != '0) && (prec_of(cmd.op) <= prec_of(top_op));

        if (cmd_valid)
        begin
            unique case (cmd.kind)
                CMD_COND:
                begin
                    if (can_load)
                    begin
                        load          = 1'b1;
                        out_kind_next = KIND_COND;
                        out_cond_next = cmd.cond;
                        out_last_next = 1'b1;
                        cnt_next      = cnt_inc;
                        cmd_ready     = 1'b1;
                    end
                end
                CMD_OPEN:
                begin
                    push_op   = SOP_OPEN;
                    cmd_ready = 1'b1;
                    if (ptr_reg >= PTR_W'(STACK_DEPTH))
                    begin
                        if (err_reg == ERR_NONE)
                            err_next = ERR_OVERFLOW;
                    end
                    else
                    begin
                        push_en  = 1'b1;
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
                CMD_OPER, CMD_CLOSE:
                begin
                    // a popped entry waits in the hold register until the next top
                    // tells whether it is the last result of this token
                    if (!hold_valid_reg || can_load)
                    begin
                        if (hold_valid_reg)
                        begin
                            load          = 1'b1;
                            out_op_next   = hold_op_reg;
                            out_last_next = !cont;
                        end
                        if (cont)
                        begin
                            hold_valid_next = 1'b1;
                            hold_op_next    = top_op;
                            ptr_next        = ptr_m1;
                            pop_en          = 1'b1;
                            cnt_next        = cnt_inc;
                        end
                        else
                        begin
                            hold_valid_next = 1'b0;
                            cmd_ready       = 1'b1;
                            if (cmd.kind == CMD_CLOSE)
                            begin
                                if (ptr_reg != '0)
                                begin
                                    ptr_next = ptr_m1;
                                    pop_en   = 1'b1;
                                end
                                else if (err_reg == ERR_NONE)
                                    err_next = ERR_UNMATCH;
                            end
                            else if (ptr_reg >= PTR_W'(STACK_DEPTH))
                            begin
                                if (err_reg == ERR_NONE)
                                    err_next = ERR_OVERFLOW;
                            end
                            else
                            begin
                                push_en  = 1'b1;
                                ptr_next = ptr_reg + PTR_W'(1);
                            end
                        end
                    end
                end
                CMD_END:
                begin
                    if (can_load)
                    begin
                        load = 1'b1;
                        if (ptr_reg != '0)
                        begin
                            out_op_next = top_op;
                            ptr_next    = ptr_m1;
                            pop_en      = 1'b1;
                            cnt_next    = cnt_inc;
                        end
                        else
                        begin
                            out_kind_next  = KIND_DONE;
                            out_count_next = cnt_reg;
                            out_last_next  = 1'b1;
                            ptr_next       = '0;
                            cnt_next       = '0;
                            err_next       = ERR_NONE;
                            cmd_ready      = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (load)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            err_reg        <= ERR_NONE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg        <= ptr_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_op_reg <= hold_op_next;
        if (push_en)
        begin
            stack_mem[ptr_reg[IDX_W-1:0]] <= push_op;
            top_reg                       <= push_op;
        end
        else if (pop_en)
            top_reg <= stack_mem[ptr_m2[IDX_W-1:0]];
        if (load)
        begin
            out_kind_reg  <= out_kind_next;
            out_op_reg    <= out_op_next;
            out_cond_reg  <= out_cond_next;
            out_count_reg <= out_count_next;
            out_err_reg   <= out_err_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_kind   = out_kind_reg;
    assign results.out_op     = out_op_reg;
    assign results.out_cond   = out_cond_reg;
    assign results.out_count  = out_count_reg;
    assign results.error_code = out_err_reg;
    assign results.last       = out_last_reg;

endmodule

@@ rtl/boolean_infix_to_postfix_unit.sv @@
// top level: boolean infix to postfix reorderer with operator stack
//
//   channel   dir   transfer holds
//   tokens    in    mode, op_code, cond_index
//   results   out   out_kind, out_op, out_cond, out_count, error_code, last
//
// a condition is emitted and an open bracket is pushed; an operator or close
// bracket pops stack entries, then is itself pushed or discarded; the end
// marker pops every entry, then emits the done item. the pop loop moves one
// stack entry a cycle unless the results channel stalls.
// reset clears pointer, count and error; stack contents stay undefined.
// a two-entry command queue lets the front take tokens while the back stalls.
module boolean_infix_to_postfix_unit
    import bip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bip_in_if.sink     tokens,
    bip_out_if.source  results
);

    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    bip_front u_front (
        .tokens    (tokens),
        .cmd_valid (fq_valid),
        .cmd       (fq_cmd),
        .cmd_ready (fq_ready)
    );

    bip_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_cmd   (fq_cmd),
        .wr_ready (fq_ready),
        .rd_valid (qb_valid),
        .rd_cmd   (qb_cmd),
        .rd_ready (qb_ready)
    );

    bip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd       (qb_cmd),
        .cmd_ready (qb_ready),
        .results   (results)
    );

endmodule
